[design/rqi_pkg.sv]
`default_nettype none
package rqi_pkg;

  localparam int COMP_W    = 21;
  localparam int VEC_W     = 3 * COMP_W;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int DEN_W     = 55;
  localparam int NUM_W     = 56;
  localparam int DIV_STEPS = 48;
  localparam int FRAC_W    = 16;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef enum logic [2:0] {
    REG_CORNER,
    REG_EDGE_U,
    REG_EDGE_V,
    REG_NORMAL,
    REG_INV_NORMAL,
    REG_OFFSET,
    REG_MATERIAL
  } reg_idx_t;

  // ray context carried alongside the divider
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic [31:0]      tmin;
    logic [31:0]      tmax;
    logic             neg;
    logic             front;
    logic             par;
  } ray_ctx_t;

  // context carried after t is known
  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
    logic             front;
    logic             miss;
  } post_ctx_t;

  // signed Q9.12 component i of a packed vector
  function automatic comp_t vec_comp(input logic [VEC_W-1:0] v, input logic [1:0] i);
    return comp_t'(v[COMP_W*i +: COMP_W]);
  endfunction

endpackage
`default_nettype wire

[design/ray_quad_intersect_top.sv]
`default_nettype none
// Ray / parallelogram intersector. One ray (origin, direction, inclusive t interval,
// all signed Q16.16) enters per clock while the pipe is not stalled, and one result
// leaves per ray, in order, after the plane dot products, the setup of the divide,
// a restoring divider that retires one quotient bit per stage, and the hit point,
// the planar coordinates and the output register. The whole pipe advances together
// whenever the output register is empty or being taken, so a stall holds every stage
// in place. The quad (corner, edges, unit normal, scaled normal w, plane offset,
// material) sits in APB registers at byte address 8*i; write them only while no ray
// is in flight. A miss returns hit=0 with every other field zero.
module ray_quad_intersect_top
  import rqi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // apb configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  // ray channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       origin_x,
  input  logic signed [31:0]       origin_y,
  input  logic signed [31:0]       origin_z,
  input  logic signed [31:0]       dir_x,
  input  logic signed [31:0]       dir_y,
  input  logic signed [31:0]       dir_z,
  input  logic signed [31:0]       t_min,
  input  logic signed [31:0]       t_max,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic signed [31:0]       hit_t,
  output logic signed [31:0]       point_x,
  output logic signed [31:0]       point_y,
  output logic signed [31:0]       point_z,
  output logic [16:0]              coord_alpha,
  output logic [16:0]              coord_beta,
  output logic                     front_face,
  output logic signed [17:0]       normal_x,
  output logic signed [17:0]       normal_y,
  output logic signed [17:0]       normal_z,
  output logic [7:0]               hit_material
);

  // ---------------------------------------------------------------- registers
  logic [VEC_W-1:0]  corner_vec, edge_u_vec, edge_v_vec, unit_normal_vec, inv_normal_vec;
  logic signed [31:0] plane_offset;
  logic [7:0]         material_index;
  reg_idx_t           reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_vec      <= '0;
      edge_u_vec      <= '0;
      edge_v_vec      <= '0;
      unit_normal_vec <= '0;
      inv_normal_vec  <= '0;
      plane_offset    <= '0;
      material_index  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CORNER:     corner_vec      <= pwdata[VEC_W-1:0];
        REG_EDGE_U:     edge_u_vec      <= pwdata[VEC_W-1:0];
        REG_EDGE_V:     edge_v_vec      <= pwdata[VEC_W-1:0];
        REG_NORMAL:     unit_normal_vec <= pwdata[VEC_W-1:0];
        REG_INV_NORMAL: inv_normal_vec  <= pwdata[VEC_W-1:0];
        REG_OFFSET:     plane_offset    <= pwdata[31:0];
        REG_MATERIAL:   material_index  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CORNER:     prdata = {1'b0, corner_vec};
      REG_EDGE_U:     prdata = {1'b0, edge_u_vec};
      REG_EDGE_V:     prdata = {1'b0, edge_v_vec};
      REG_NORMAL:     prdata = {1'b0, unit_normal_vec};
      REG_INV_NORMAL: prdata = {1'b0, inv_normal_vec};
      REG_OFFSET:     prdata = {32'd0, plane_offset};
      REG_MATERIAL:   prdata = {56'd0, material_index};
      default:        prdata = '0;
    endcase
  end

  // quad components; the user must keep them static while rays are in flight, the block does not enforce it
  comp_t n_c[3], q_c[3], u_c[3], v_c[3], w_c[3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i] = vec_comp(unit_normal_vec, 2'(i));
      q_c[i] = vec_comp(corner_vec, 2'(i));
      u_c[i] = vec_comp(edge_u_vec, 2'(i));
      v_c[i] = vec_comp(edge_v_vec, 2'(i));
      w_c[i] = vec_comp(inv_normal_vec, 2'(i));
    end
  end

  // whole pipe moves when the output register is free or being drained
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic signed [31:0] in_org[3], in_dir[3];
  assign in_org[0] = origin_x;
  assign in_org[1] = origin_y;
  assign in_org[2] = origin_z;
  assign in_dir[0] = dir_x;
  assign in_dir[1] = dir_y;
  assign in_dir[2] = dir_z;

  // ---------------------------------------------------------------- s1: products
  logic               s1_valid;
  ray_ctx_t           s1_ctx;
  logic signed [52:0] s1_nd[3], s1_no[3];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_nd[i]      <= n_c[i] * in_dir[i];
        s1_no[i]      <= n_c[i] * in_org[i];
        s1_ctx.org[i] <= in_org[i];
        s1_ctx.dir[i] <= in_dir[i];
      end
      s1_ctx.tmin  <= t_min;
      s1_ctx.tmax  <= t_max;
      s1_ctx.neg   <= 1'b0;
      s1_ctx.front <= 1'b0;
      s1_ctx.par   <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- s2: sums
  logic                    s2_valid;
  ray_ctx_t                s2_ctx;
  logic signed [DEN_W-1:0] s2_den;
  logic signed [NUM_W-1:0] s2_num;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_den <= s1_nd[0] + s1_nd[1] + s1_nd[2];
      s2_num <= (plane_offset * 4096) - s1_no[0] - s1_no[1] - s1_no[2];
      s2_ctx <= s1_ctx;
    end
  end

  // ---------------------------------------------------------------- s3: magnitudes
  logic             s3_valid;
  ray_ctx_t         s3_ctx;
  logic [NUM_W-1:0] s3_un;
  logic [DEN_W-1:0] s3_ud;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= s2_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_un        <= (s2_num < 0) ? NUM_W'(-s2_num) : NUM_W'(s2_num);
      s3_ud        <= (s2_den < 0) ? DEN_W'(-s2_den) : DEN_W'(s2_den);
      s3_ctx.org   <= s2_ctx.org;
      s3_ctx.dir   <= s2_ctx.dir;
      s3_ctx.tmin  <= s2_ctx.tmin;
      s3_ctx.tmax  <= s2_ctx.tmax;
      s3_ctx.neg   <= (s2_num < 0) != (s2_den < 0);
      s3_ctx.front <= s2_den < 0;
      s3_ctx.par   <= s2_den == 0;
    end
  end

  // ---------------------------------------------------------------- divider
  // entry 0 is the setup stage, entry j+1 holds the result of quotient step j
  logic             dv_valid[DIV_STEPS+1];
  ray_ctx_t         dv_ctx[DIV_STEPS+1];
  logic [DEN_W-1:0] dv_rem[DIV_STEPS+1];
  logic [DEN_W-1:0] dv_ud[DIV_STEPS+1];
  logic [31:0]      dv_lo[DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dv_q[DIV_STEPS+1];
  logic             dv_ovf[DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (adv) dv_valid[0] <= s3_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      // integer part of |t| at 2^32 or more clamps
      dv_ovf[0] <= DEN_W'(s3_un[NUM_W-1:32]) >= s3_ud;
      dv_rem[0] <= DEN_W'(s3_un[NUM_W-1:32]);
      dv_lo[0]  <= s3_un[31:0];
      dv_ud[0]  <= s3_ud;
      dv_q[0]   <= '0;
      dv_ctx[0] <= s3_ctx;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int K = DIV_STEPS - 1 - j;
    logic             nb;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (K >= FRAC_W) begin : g_bit
      assign nb = dv_lo[j][K-FRAC_W];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {dv_rem[j], nb};
    assign ge    = trial >= {1'b0, dv_ud[j]};
    assign diff  = trial - {1'b0, dv_ud[j]};

    always_ff @(posedge clk) begin
      if (rst) dv_valid[j+1] <= 1'b0;
      else if (adv) dv_valid[j+1] <= dv_valid[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        dv_q[j+1]   <= {dv_q[j][DIV_STEPS-2:0], ge};
        dv_lo[j+1]  <= dv_lo[j];
        dv_ud[j+1]  <= dv_ud[j];
        dv_ovf[j+1] <= dv_ovf[j];
        dv_ctx[j+1] <= dv_ctx[j];
      end
    end
  end

  // ---------------------------------------------------------------- ts: sign and interval
  ray_ctx_t           dq_ctx;
  logic [DIV_STEPS:0] dq_mag;
  logic signed [DIV_STEPS+1:0] dq_t;
  logic               dq_in;

  assign dq_ctx = dv_ctx[DIV_STEPS];
  assign dq_mag = dv_ovf[DIV_STEPS] ? {1'b1, {DIV_STEPS{1'b0}}}
                                    : {1'b0, dv_q[DIV_STEPS]};
  assign dq_t   = dq_ctx.neg ? -$signed({1'b0, dq_mag}) : $signed({1'b0, dq_mag});
  assign dq_in  = (dq_t >= $signed(dq_ctx.tmin)) && (dq_t <= $signed(dq_ctx.tmax));

  logic               ts_valid;
  post_ctx_t          ts_ctx;
  logic signed [31:0] ts_t;

  always_ff @(posedge clk) begin
    if (rst) ts_valid <= 1'b0;
    else if (adv) ts_valid <= dv_valid[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      // in range implies t fits 32 bits
      ts_t         <= dq_t[31:0];
      ts_ctx.org   <= dq_ctx.org;
      ts_ctx.dir   <= dq_ctx.dir;
      ts_ctx.front <= dq_ctx.front;
      ts_ctx.miss  <= dq_ctx.par || !dq_in;
    end
  end

  // ---------------------------------------------------------------- mul: t*dir
  logic               mu_valid;
  post_ctx_t          mu_ctx;
  logic signed [31:0] mu_t;
  logic signed [63:0] mu_p[3];

  always_ff @(posedge clk) begin
    if (rst) mu_valid <= 1'b0;
    else if (adv) mu_valid <= ts_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) mu_p[i] <= ts_t * $signed(ts_ctx.dir[i]);
      mu_t   <= ts_t;
      mu_ctx <= ts_ctx;
    end
  end

  // ---------------------------------------------------------------- sm: origin + floor
  logic               sm_valid;
  post_ctx_t          sm_ctx;
  logic signed [31:0] sm_t;
  logic signed [48:0] sm_s[3];

  always_ff @(posedge clk) begin
    if (rst) sm_valid <= 1'b0;
    else if (adv) sm_valid <= mu_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++)
        sm_s[i] <= $signed(mu_ctx.org[i]) + $signed(mu_p[i][63:16]);
      sm_t   <= mu_t;
      sm_ctx <= mu_ctx;
    end
  end

  // ---------------------------------------------------------------- pt: saturate, relative point
  logic signed [31:0] pt_c[3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sm_s[i] > 49'sd2147483647)       pt_c[i] = 32'sh7FFF_FFFF;
      else if (sm_s[i] < -49'sd2147483648) pt_c[i] = 32'sh8000_0000;
      else                                 pt_c[i] = sm_s[i][31:0];
    end
  end

  logic               pt_valid;
  post_ctx_t          pt_ctx;
  logic signed [31:0] pt_t;
  logic signed [31:0] pt_pt[3];
  logic signed [33:0] pt_p[3];

  always_ff @(posedge clk) begin
    if (rst) pt_valid <= 1'b0;
    else if (adv) pt_valid <= sm_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pt_pt[i] <= pt_c[i];
        pt_p[i]  <= pt_c[i] - (q_c[i] <<< 4);
      end
      pt_t   <= sm_t;
      pt_ctx <= sm_ctx;
    end
  end

  // ---------------------------------------------------------------- cr: cross products
  logic               cr_valid;
  post_ctx_t          cr_ctx;
  logic signed [31:0] cr_t;
  logic signed [31:0] cr_pt[3];
  logic signed [54:0] cr_al[3], cr_ar[3], cr_bl[3], cr_br[3];

  always_ff @(posedge clk) begin
    if (rst) cr_valid <= 1'b0;
    else if (adv) cr_valid <= pt_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      // cross(P, v)
      cr_al[0] <= pt_p[1] * v_c[2];  cr_ar[0] <= pt_p[2] * v_c[1];
      cr_al[1] <= pt_p[2] * v_c[0];  cr_ar[1] <= pt_p[0] * v_c[2];
      cr_al[2] <= pt_p[0] * v_c[1];  cr_ar[2] <= pt_p[1] * v_c[0];
      // cross(u, P)
      cr_bl[0] <= u_c[1] * pt_p[2];  cr_br[0] <= u_c[2] * pt_p[1];
      cr_bl[1] <= u_c[2] * pt_p[0];  cr_br[1] <= u_c[0] * pt_p[2];
      cr_bl[2] <= u_c[0] * pt_p[1];  cr_br[2] <= u_c[1] * pt_p[0];
      cr_pt  <= pt_pt;
      cr_t   <= pt_t;
      cr_ctx <= pt_ctx;
    end
  end

  // ---------------------------------------------------------------- cl: shift and clamp
  localparam logic signed [43:0] LIM_HI = 44'sh1FF_FFFF_FFFF;
  localparam logic signed [43:0] LIM_LO = -LIM_HI;

  logic signed [55:0] cl_da[3], cl_db[3];
  logic signed [43:0] cl_sa[3], cl_sb[3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cl_da[i] = cr_al[i] - cr_ar[i];
      cl_db[i] = cr_bl[i] - cr_br[i];
      cl_sa[i] = cl_da[i][55:12];
      cl_sb[i] = cl_db[i][55:12];
    end
  end

  logic               cl_valid;
  post_ctx_t          cl_ctx;
  logic signed [31:0] cl_t;
  logic signed [31:0] cl_pt[3];
  logic signed [41:0] cl_a[3], cl_b[3];

  always_ff @(posedge clk) begin
    if (rst) cl_valid <= 1'b0;
    else if (adv) cl_valid <= cr_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (cl_sa[i] > LIM_HI)      cl_a[i] <= LIM_HI[41:0];
        else if (cl_sa[i] < LIM_LO) cl_a[i] <= LIM_LO[41:0];
        else                        cl_a[i] <= cl_sa[i][41:0];
        if (cl_sb[i] > LIM_HI)      cl_b[i] <= LIM_HI[41:0];
        else if (cl_sb[i] < LIM_LO) cl_b[i] <= LIM_LO[41:0];
        else                        cl_b[i] <= cl_sb[i][41:0];
      end
      cl_pt  <= cr_pt;
      cl_t   <= cr_t;
      cl_ctx <= cr_ctx;
    end
  end

  // ---------------------------------------------------------------- wm: dot with w
  logic               wm_valid;
  post_ctx_t          wm_ctx;
  logic signed [31:0] wm_t;
  logic signed [31:0] wm_pt[3];
  logic signed [62:0] wm_a[3], wm_b[3];

  always_ff @(posedge clk) begin
    if (rst) wm_valid <= 1'b0;
    else if (adv) wm_valid <= cl_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        wm_a[i] <= w_c[i] * cl_a[i];
        wm_b[i] <= w_c[i] * cl_b[i];
      end
      wm_pt  <= cl_pt;
      wm_t   <= cl_t;
      wm_ctx <= cl_ctx;
    end
  end

  // ---------------------------------------------------------------- final decision
  logic signed [64:0] fn_sa, fn_sb;
  logic signed [52:0] fn_alpha, fn_beta;
  logic               fn_hit;
  logic signed [25:0] fn_n[3];
  logic signed [17:0] fn_nc[3];

  always_comb begin
    fn_sa    = wm_a[0] + wm_a[1] + wm_a[2];
    fn_sb    = wm_b[0] + wm_b[1] + wm_b[2];
    fn_alpha = fn_sa[64:12];
    fn_beta  = fn_sb[64:12];
    fn_hit   = !wm_ctx.miss
               && fn_alpha >= 0 && fn_alpha <= 53'sd65536
               && fn_beta  >= 0 && fn_beta  <= 53'sd65536;
    for (int i = 0; i < 3; i++) begin
      // normal turned toward the ray
      fn_n[i] = wm_ctx.front ? (n_c[i] <<< 4) : -(n_c[i] <<< 4);
      if (fn_n[i] > 26'sd65536)       fn_nc[i] = 18'sd65536;
      else if (fn_n[i] < -26'sd65536) fn_nc[i] = -18'sd65536;
      else                            fn_nc[i] = fn_n[i][17:0];
    end
  end

  // output register, zeroed on a miss
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= wm_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hit          <= fn_hit;
      hit_t        <= fn_hit ? wm_t : '0;
      point_x      <= fn_hit ? wm_pt[0] : '0;
      point_y      <= fn_hit ? wm_pt[1] : '0;
      point_z      <= fn_hit ? wm_pt[2] : '0;
      coord_alpha  <= fn_hit ? fn_alpha[16:0] : '0;
      coord_beta   <= fn_hit ? fn_beta[16:0] : '0;
      front_face   <= fn_hit && wm_ctx.front;
      normal_x     <= fn_hit ? fn_nc[0] : '0;
      normal_y     <= fn_hit ? fn_nc[1] : '0;
      normal_z     <= fn_hit ? fn_nc[2] : '0;
      hit_material <= fn_hit ? material_index : '0;
    end
  end

  // ---------------------------------------------------------------- checks
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> coord_alpha <= 17'd65536 && coord_beta <= 17'd65536)
    else $error("planar coordinate outside unit range on a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_t == 0 && hit_material == 0 && !front_face)
    else $error("miss transaction carries nonzero fields");

  a_material: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> hit_material == material_index)
    else $error("hit material differs from configured material");

endmodule
`default_nettype wire

[verif/ray_quad_intersect_top_tb.sv]
`timescale 1ns / 1ps
module ray_quad_intersect_top_tb
  import rqi_pkg::*;
;

  localparam int ONE = 65536;           // 1.0 in q16.16
  localparam int Q12_ONE = 4096;        // 1.0 in q9.12
  localparam int UNUSED_REG_IDX = 7;    // no register behind this index
  localparam int SETTLE_CYCLES = 70;    // pipe depth plus margin
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    int org[3];
    int dir[3];
    int tmin;
    int tmax;
  } ray_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] alpha;
    logic [16:0] beta;
    logic        front;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [17:0] nz;
    logic [7:0]  mat;
  } hit_rec_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic signed [31:0] t_min = 0, t_max = 0;
  logic out_valid;
  logic out_ready = 0;
  logic hit, front_face;
  logic signed [31:0] hit_t, point_x, point_y, point_z;
  logic [16:0] coord_alpha, coord_beta;
  logic signed [17:0] normal_x, normal_y, normal_z;
  logic [7:0] hit_material;

  ray_quad_intersect_top dut (.*);

  always #5 clk = ~clk;

  // quad as the block should hold it
  logic [VEC_W-1:0] quad_corner = '0, quad_u = '0, quad_v = '0;
  logic [VEC_W-1:0] quad_normal = '0, quad_w = '0;
  int               quad_offset = 0;
  logic [7:0]       quad_material = '0;

  // geometry of the current axis-aligned quad, used to aim rays
  int axis_n, axis_u, axis_v, log_u, log_v;
  int corner_q12[3];

  hit_rec_t expected_hits[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_cycle = 0;

  function automatic longint q12_comp(logic [VEC_W-1:0] v, int i);
    logic signed [COMP_W-1:0] c;
    c = v[COMP_W*i +: COMP_W];
    return longint'(c);
  endfunction

  function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
    return {z[COMP_W-1:0], y[COMP_W-1:0], x[COMP_W-1:0]};
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // expected result of one ray against the configured quad
  function automatic hit_rec_t predict_hit(ray_t r);
    longint o[3], d[3], n[3], q[3], u[3], v[3], w[3];
    longint pt[3], p[3], ca[3], cb[3];
    longint den, num, t, al, be, nn, lim;
    logic [63:0] un, ud, qi, rem, frac, mag;
    logic neg, front;
    hit_rec_t res;
    res = '0;
    lim = (longint'(1) <<< 41) - 1;
    for (int i = 0; i < 3; i++) begin
      o[i] = r.org[i];
      d[i] = r.dir[i];
      n[i] = q12_comp(quad_normal, i);
      q[i] = q12_comp(quad_corner, i);
      u[i] = q12_comp(quad_u, i);
      v[i] = q12_comp(quad_v, i);
      w[i] = q12_comp(quad_w, i);
    end
    den = 0;
    for (int i = 0; i < 3; i++) den += n[i] * d[i];
    if (den == 0) return res;  // parallel to the plane
    num = longint'(quad_offset) * 4096;
    for (int i = 0; i < 3; i++) num -= n[i] * o[i];
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    qi = un / ud;
    if (qi >= 64'h1_0000_0000) begin
      mag = 64'h1_0000_0000_0000;  // oversized t clamps and never passes
    end else begin
      rem = un % ud;
      frac = '0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        frac = frac << 1;
        if (rem >= ud) begin
          rem -= ud;
          frac[0] = 1'b1;
        end
      end
      mag = (qi << 16) | frac;
    end
    t = neg ? -longint'(mag) : longint'(mag);
    if (t < r.tmin || t > r.tmax) return res;
    for (int i = 0; i < 3; i++) begin
      pt[i] = clamp(o[i] + ((t * d[i]) >>> 16), -64'sd2147483648, 64'sd2147483647);
      p[i] = pt[i] - q[i] * 16;
    end
    ca[0] = p[1] * v[2] - p[2] * v[1];
    ca[1] = p[2] * v[0] - p[0] * v[2];
    ca[2] = p[0] * v[1] - p[1] * v[0];
    cb[0] = u[1] * p[2] - u[2] * p[1];
    cb[1] = u[2] * p[0] - u[0] * p[2];
    cb[2] = u[0] * p[1] - u[1] * p[0];
    al = 0;
    be = 0;
    for (int i = 0; i < 3; i++) begin
      al += w[i] * clamp(ca[i] >>> 12, -lim, lim);
      be += w[i] * clamp(cb[i] >>> 12, -lim, lim);
    end
    al = al >>> 12;
    be = be >>> 12;
    if (al < 0 || al > ONE || be < 0 || be > ONE) return res;
    front = den < 0;
    res.hit = 1'b1;
    res.t = t[31:0];
    res.px = pt[0][31:0];
    res.py = pt[1][31:0];
    res.pz = pt[2][31:0];
    res.alpha = al[16:0];
    res.beta = be[16:0];
    res.front = front;
    nn = clamp(front ? n[0] * 16 : -n[0] * 16, -ONE, ONE);
    res.nx = nn[17:0];
    nn = clamp(front ? n[1] * 16 : -n[1] * 16, -ONE, ONE);
    res.ny = nn[17:0];
    nn = clamp(front ? n[2] * 16 : -n[2] * 16, -ONE, ONE);
    res.nz = nn[17:0];
    res.mat = quad_material;
    return res;
  endfunction

  function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int tlo, int thi);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.tmin = tlo;
    r.tmax = thi;
    return r;
  endfunction

  // register write: setup phase, access phase, then an idle phase with psel low
  task automatic reg_write(int idx, logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CORNER:     quad_corner = val[VEC_W-1:0];
      REG_EDGE_U:     quad_u = val[VEC_W-1:0];
      REG_EDGE_V:     quad_v = val[VEC_W-1:0];
      REG_NORMAL:     quad_normal = val[VEC_W-1:0];
      REG_INV_NORMAL: quad_w = val[VEC_W-1:0];
      REG_OFFSET:     quad_offset = val[31:0];
      REG_MATERIAL:   quad_material = val[7:0];
      default: ;  // unknown index, write is dropped
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // present one ray; sender runs in bursts with random gaps
  task automatic send_ray(ray_t r, logic typed, hit_rec_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    origin_x <= r.org[0];
    origin_y <= r.org[1];
    origin_z <= r.org[2];
    dir_x <= r.dir[0];
    dir_y <= r.dir[1];
    dir_z <= r.dir[2];
    t_min <= r.tmin;
    t_max <= r.tmax;
    do @(posedge clk); while (!in_ready);
    expected_hits.push_back(typed ? want : predict_hit(r));
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // axis-aligned quad; each edge is the unit shifted left by log_u or log_v, so w is exact
  task automatic load_axis_quad();
    int sgn;
    int nv[3], uv[3], vv[3], wv[3];
    axis_n = $urandom_range(0, 2);
    axis_u = (axis_n + 1) % 3;
    axis_v = (axis_n + 2) % 3;
    log_u = $urandom_range(0, 3);
    log_v = $urandom_range(0, 3);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < 3; i++) begin
      corner_q12[i] = int'($urandom_range(0, 65536)) - 32768;
      nv[i] = 0;
      uv[i] = 0;
      vv[i] = 0;
      wv[i] = 0;
    end
    nv[axis_n] = sgn * Q12_ONE;
    uv[axis_u] = Q12_ONE << log_u;
    vv[axis_v] = Q12_ONE << log_v;
    wv[axis_n] = Q12_ONE >> (log_u + log_v);
    reg_write(REG_CORNER, pack_vec(corner_q12[0], corner_q12[1], corner_q12[2]));
    reg_write(REG_EDGE_U, pack_vec(uv[0], uv[1], uv[2]));
    reg_write(REG_EDGE_V, pack_vec(vv[0], vv[1], vv[2]));
    reg_write(REG_NORMAL, pack_vec(nv[0], nv[1], nv[2]));
    reg_write(REG_INV_NORMAL, pack_vec(wv[0], wv[1], wv[2]));
    reg_write(REG_OFFSET, 64'(sgn * corner_q12[axis_n] * 16));
    reg_write(REG_MATERIAL, 64'($urandom_range(0, 255)));
  endtask

  function automatic ray_t noise_ray();
    ray_t r;
    for (int i = 0; i < 3; i++) begin
      r.org[i] = $urandom;
      r.dir[i] = $urandom;
    end
    r.tmin = $urandom;
    r.tmax = $urandom;
    return r;
  endfunction

  // ray aimed at a point near the quad, mostly inside it
  function automatic ray_t aimed_ray();
    ray_t r;
    hit_rec_t probe;
    int pt[3], al, be, t, mode;
    al = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? ONE : 0)
                                      : int'($urandom_range(0, 91750)) - 13107;
    be = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? ONE : 0)
                                      : int'($urandom_range(0, 91750)) - 13107;
    for (int i = 0; i < 3; i++) pt[i] = corner_q12[i] * 16;
    pt[axis_u] += al * (1 << log_u);
    pt[axis_v] += be * (1 << log_v);
    t = $urandom_range(ONE, 16 * ONE);
    for (int i = 0; i < 3; i++) r.dir[i] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
    r.dir[axis_n] = $urandom_range(16384, 262144) * ($urandom_range(0, 1) ? 1 : -1);
    mode = $urandom_range(0, 9);
    if (mode == 0) r.dir[axis_n] = 0;  // parallel ray
    for (int i = 0; i < 3; i++) r.org[i] = pt[i] - int'((longint'(t) * r.dir[i]) >>> 16);
    r.tmin = 0;
    r.tmax = 32'h7FFF_FFFF;
    if (mode == 1) begin
      // interval pinned exactly on t
      probe = predict_hit(r);
      if (probe.hit) begin
        r.tmin = probe.t;
        r.tmax = probe.t;
      end
    end else if (mode == 2) begin
      r.tmax = $urandom_range(0, 17 * ONE);
    end else if (mode == 3) begin
      r.tmin = int'($urandom_range(0, 34 * ONE)) - 17 * ONE;
    end
    return r;
  endfunction

  // result side: the stall pattern steps through four modes, chosen by rx_cycle bits 8:7
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= $urandom_range(0, 1);
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle[2:0] != 3'd0);
    endcase
  end

  // compare each result transaction with the oldest expectation, plus watchdog
  always @(posedge clk) begin
    hit_rec_t got, want;
    logic any_accept;
    any_accept = (in_valid && in_ready) || (out_valid && out_ready);
    if (!rst && out_valid && out_ready) begin
      got = '{hit, hit_t, point_x, point_y, point_z, coord_alpha, coord_beta,
              front_face, normal_x, normal_y, normal_z, hit_material};
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_hits.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
    if ((in_valid || expected_hits.size() != 0) && !any_accept) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  ray_t     dir_rows[12];
  logic     row_typed[12];
  hit_rec_t row_want[12];

  initial begin
    ray_t r;
    hit_rec_t zero_rec;
    zero_rec = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rays, aimed at a 4x4 quad in the z=0 plane
    dir_rows[0]  = make_ray(2*ONE, 2*ONE, 5*ONE, 0, 0, -ONE, 0, 32'h7FFF_FFFF);
    dir_rows[1]  = make_ray(0, 0, 5*ONE, 0, 0, -ONE, 0, 32'h7FFF_FFFF);
    dir_rows[2]  = make_ray(4*ONE, 4*ONE, 5*ONE, 0, 0, -ONE, 0, 32'h7FFF_FFFF);
    dir_rows[3]  = make_ray(4*ONE + 1, 2*ONE, 5*ONE, 0, 0, -ONE, 0, 32'h7FFF_FFFF);
    dir_rows[4]  = make_ray(ONE, ONE, -3*ONE, 0, 0, ONE, 0, 32'h7FFF_FFFF);
    dir_rows[5]  = make_ray(ONE, ONE, 5*ONE, ONE, 0, 0, 0, 32'h7FFF_FFFF);
    dir_rows[6]  = make_ray(ONE, ONE, 5*ONE, 0, 0, -ONE, 5*ONE, 5*ONE);
    dir_rows[7]  = make_ray(ONE, ONE, 5*ONE, 0, 0, -ONE, 0, 5*ONE - 1);
    dir_rows[8]  = make_ray(ONE, ONE, -5*ONE, 0, 0, -ONE, 32'h8000_0000, 32'h7FFF_FFFF);
    dir_rows[9]  = make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF);
    dir_rows[10] = make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF);
    dir_rows[11] = make_ray(ONE, ONE, 32'h7FFF_FFFF, 0, 0, -1, 0, 32'h7FFF_FFFF);
    foreach (row_typed[i]) begin
      row_typed[i] = 1'b0;
      row_want[i] = '0;
    end
    // straight down onto the corner: alpha and beta zero, front face
    row_typed[1] = 1'b1;
    row_want[1] = '{1'b1, 32'(5*ONE), 32'd0, 32'd0, 32'd0, 17'd0, 17'd0, 1'b1,
                    18'd0, 18'd0, 18'(ONE), 8'h5A};

    // registers at reset: normal is zero, every ray is parallel and misses
    foreach (dir_rows[i]) send_ray(dir_rows[i], 1'b1, zero_rec);
    drain();

    reg_write(REG_CORNER, pack_vec(0, 0, 0));
    reg_write(REG_EDGE_U, pack_vec(4*Q12_ONE, 0, 0));
    reg_write(REG_EDGE_V, pack_vec(0, 4*Q12_ONE, 0));
    reg_write(REG_NORMAL, pack_vec(0, 0, Q12_ONE));
    reg_write(REG_INV_NORMAL, pack_vec(0, 0, Q12_ONE / 16));
    reg_write(REG_OFFSET, 64'd0);
    reg_write(REG_MATERIAL, 64'h5A);
    foreach (dir_rows[i]) send_ray(dir_rows[i], row_typed[i], row_want[i]);
    drain();

    // random quads, mostly aimed rays with some noise
    for (int ph = 0; ph < 6; ph++) begin
      load_axis_quad();
      if (ph == 1) reg_write(UNUSED_REG_IDX, {DATA_W{1'b1}});  // must be ignored
      repeat (225) begin
        r = ($urandom_range(0, 6) == 0) ? noise_ray() : aimed_ray();
        send_ray(r, 1'b0, zero_rec);
      end
      drain();
    end

    // all-ones registers, then oversized normal with extreme offset
    for (int ph = 0; ph < 2; ph++) begin
      if (ph == 0) begin
        reg_write(REG_CORNER, {DATA_W{1'b1}});
        reg_write(REG_EDGE_U, {DATA_W{1'b1}});
        reg_write(REG_EDGE_V, {DATA_W{1'b1}});
        reg_write(REG_NORMAL, {DATA_W{1'b1}});
        reg_write(REG_INV_NORMAL, {DATA_W{1'b1}});
        reg_write(REG_OFFSET, 64'h8000_0000);
        reg_write(REG_MATERIAL, 64'hFF);
      end else begin
        reg_write(REG_CORNER, '0);
        reg_write(REG_EDGE_U, pack_vec(32'h0F_FFFF, 0, 0));
        reg_write(REG_EDGE_V, pack_vec(0, 32'h10_0000, 0));
        reg_write(REG_NORMAL, pack_vec(32'h0F_FFFF, 32'h10_0000, 32'h0F_FFFF));
        reg_write(REG_INV_NORMAL, pack_vec(32'h10_0000, 32'h0F_FFFF, 32'h10_0000));
        reg_write(REG_OFFSET, 64'h7FFF_FFFF);
        reg_write(REG_MATERIAL, 64'h00);
      end
      repeat (40) send_ray(($urandom_range(0, 1) ? noise_ray() : aimed_ray()), 1'b0,
                           zero_rec);
      drain();
    end

    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rqi_pkg.sv
design/ray_quad_intersect_top.sv
verif/ray_quad_intersect_top_tb.sv
